/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/core/gnms_pkg.sv */
// ----------------------------------------------------------------------------
// gnms_pkg
// Types and constants shared by the suppression block.
// ----------------------------------------------------------------------------
package gnms_pkg;

    // Configuration register indexes.
    localparam logic CFG_IOU_THR    = 1'b0;
    localparam logic CFG_KEEP_LIMIT = 1'b1;

    // Input commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // One stored candidate box.
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] score;
        logic [7:0]  cls;
    } t_entry;

    // Control broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic   ins;
        logic   pop;
        logic   clr;
        t_entry new_entry;
    } t_cell_ctl;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_CHK,
        S_C0,
        S_C1,
        S_C2,
        S_C3,
        S_C4,
        S_EMIT
    } t_state;

endpackage

/* rtl/core/greedy_class_nms.sv */
// ----------------------------------------------------------------------------
// greedy_class_nms
// Per-class greedy non-maximum suppression over a score-sorted chain.
// ----------------------------------------------------------------------------
// On a load transfer the box drops into a chain of TOP_K cells that stays
// sorted by descending score, ties keeping load order, and a full chain
// drops the lowest box. A run transfer pops the chain head one box per step;
// each popped box is compared against the kept boxes one at a time, each
// compare being one check step plus five steps with the shared overlap unit,
// and the compares stop early when the box is suppressed. Results then go
// out one per cycle while the output is taken. A new transfer is accepted
// only after the last result of a run has gone out.
// ----------------------------------------------------------------------------
module greedy_class_nms
    import gnms_pkg::*;
#(
    parameter int TOP_K    = 256,
    parameter int MAX_KEEP = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [15:0] i_box_x,
    input  logic [15:0] i_box_y,
    input  logic [15:0] i_box_w,
    input  logic [15:0] i_box_h,
    input  logic [15:0] i_score,
    input  logic [7:0]  i_class_tag,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_out_x,
    output logic [15:0] o_out_y,
    output logic [15:0] o_out_w,
    output logic [15:0] o_out_h,
    output logic [15:0] o_out_score,
    output logic [7:0]  o_out_class,
    output logic        o_none_kept,
    output logic        o_last
);

    localparam int KW = $clog2(MAX_KEEP + 1);
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    t_state    r_state, n_state;
    logic [7:0] r_thr;
    logic [5:0] r_klim;
    logic [KW-1:0] r_kcnt, r_idx;
    logic [KW-1:0] w_lim;
    t_entry    r_cand;
    t_entry    r_kept [MAX_KEEP];
    t_entry    w_kept_rd;
    t_cell_ctl w_ctl;
    logic      w_supp;
    logic      w_in_xfer, w_out_xfer;
    logic      w_keep  [TOP_K];
    logic      w_cvalid[TOP_K];
    t_entry    w_centry[TOP_K];

    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = o_valid && i_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= 8'd115;
            r_klim <= 6'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IOU_THR:    r_thr  <= i_cfg_data;
                CFG_KEEP_LIMIT: r_klim <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // Effective keep limit: zero acts as one, saturating at MAX_KEEP.
    always_comb begin
        if (r_klim == 6'd0) begin
            w_lim = KW'(1);
        end else if (7'(r_klim) > 7'(MAX_KEEP)) begin
            w_lim = KW'(MAX_KEEP);
        end else begin
            w_lim = KW'(r_klim);
        end
    end

    // Chain control broadcast.
    always_comb begin
        w_ctl.ins       = w_in_xfer && (i_command == CMD_LOAD);
        w_ctl.pop       = (r_state == S_POP) && w_cvalid[0];
        w_ctl.clr       = w_out_xfer && o_last;
        w_ctl.new_entry = '{x: i_box_x, y: i_box_y, w: i_box_w, h: i_box_h,
                            score: i_score, cls: i_class_tag};
    end

    // Sorted candidate chain.
    genvar g;
    generate
        for (g = 0; g < TOP_K; g++) begin : g_cell
            logic   w_pk, w_pv, w_nv;
            t_entry w_pe, w_ne;
            if (g == 0) begin : g_head
                assign w_pk = 1'b1;
                assign w_pv = 1'b1;
                assign w_pe = w_centry[g];
            end else begin : g_body
                assign w_pk = w_keep[g-1];
                assign w_pv = w_cvalid[g-1];
                assign w_pe = w_centry[g-1];
            end
            if (g == TOP_K - 1) begin : g_tail
                assign w_nv = 1'b0;
                assign w_ne = w_centry[g];
            end else begin : g_mid
                assign w_nv = w_cvalid[g+1];
                assign w_ne = w_centry[g+1];
            end
            gnms_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_prev_keep (w_pk),
                .i_prev_valid(w_pv),
                .i_prev      (w_pe),
                .i_next_valid(w_nv),
                .i_next      (w_ne),
                .o_keep      (w_keep[g]),
                .o_valid     (w_cvalid[g]),
                .o_entry     (w_centry[g])
            );
        end
    endgenerate

    // Kept box store, read at the walk index.
    assign w_kept_rd = r_kept[r_idx[IW-1:0]];

    gnms_iou u_iou (
        .i_clk  (i_clk),
        .i_state(r_state),
        .i_cand (r_cand),
        .i_kept (w_kept_rd),
        .i_thr  (r_thr),
        .o_supp (w_supp)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_xfer && (i_command == CMD_RUN)) n_state = S_POP;
            S_POP:  n_state = w_cvalid[0] ? S_CHK : S_EMIT;
            S_CHK: begin
                if (r_idx == r_kcnt) begin
                    n_state = ((r_kcnt + KW'(1)) == w_lim) ? S_EMIT : S_POP;
                end else begin
                    n_state = S_C0;
                end
            end
            S_C0:   n_state = S_C1;
            S_C1:   n_state = S_C2;
            S_C2:   n_state = S_C3;
            S_C3:   n_state = S_C4;
            S_C4:   n_state = w_supp ? S_POP : S_CHK;
            S_EMIT: if (w_out_xfer && o_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Walk registers and kept store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kcnt  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_POP: r_idx <= '0;
                S_CHK: begin
                    if (r_idx == r_kcnt) begin
                        r_kcnt <= r_kcnt + KW'(1);
                        r_idx  <= '0;
                    end
                end
                S_C4: if (!w_supp) r_idx <= r_idx + KW'(1);
                S_EMIT: begin
                    if (w_out_xfer) begin
                        if (o_last) begin
                            r_kcnt <= '0;
                            r_idx  <= '0;
                        end else begin
                            r_idx <= r_idx + KW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_POP) r_cand <= w_centry[0];
        if ((r_state == S_CHK) && (r_idx == r_kcnt)) r_kept[r_kcnt[IW-1:0]] <= r_cand;
    end

    // Output and handshake logic.
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_valid     = (r_state == S_EMIT);
        o_none_kept = (r_kcnt == '0);
        o_last      = o_none_kept || (r_idx == (r_kcnt - KW'(1)));
        o_out_x     = o_none_kept ? 16'd0 : w_kept_rd.x;
        o_out_y     = o_none_kept ? 16'd0 : w_kept_rd.y;
        o_out_w     = o_none_kept ? 16'd0 : w_kept_rd.w;
        o_out_h     = o_none_kept ? 16'd0 : w_kept_rd.h;
        o_out_score = o_none_kept ? 16'd0 : w_kept_rd.score;
        o_out_class = o_none_kept ? 8'd0 : w_kept_rd.cls;
    end

`include "assert_macros.svh"

    `ASSERT_CLK(a_no_in_while_out, !(o_valid && o_ready), "input open during output")
    `ASSERT_CLK(a_kcnt_in_limit, r_kcnt <= w_lim, "kept count exceeds limit")
    `ASSERT_CLK(a_idle_after_last, (w_out_xfer && o_last) |=> (o_ready && !w_cvalid[0]), "store not cleared after run")
    `ASSERT_CLK(a_none_is_last, !(o_valid && o_none_kept) || o_last, "empty result without last")

endmodule

/* rtl/core/gnms_cell.sv */
// ----------------------------------------------------------------------------
// gnms_cell
// One slot of the score-sorted candidate chain.
// ----------------------------------------------------------------------------
module gnms_cell
    import gnms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_prev_keep,
    input  logic      i_prev_valid,
    input  t_entry    i_prev,
    input  logic      i_next_valid,
    input  t_entry    i_next,
    output logic      o_keep,
    output logic      o_valid,
    output t_entry    o_entry
);

    logic   r_valid;
    t_entry r_entry;
    logic   n_valid;
    t_entry n_entry;

    // A slot holds its place when its box scores at least the new one.
    assign o_keep  = r_valid && (r_entry.score >= i_ctl.new_entry.score);
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    // Insert shifts toward the tail; pop shifts toward the head.
    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctl.pop) begin
            n_valid = i_next_valid;
            n_entry = i_next;
        end else if (i_ctl.ins && !o_keep) begin
            n_valid = r_valid || i_prev_valid;
            n_entry = i_prev_keep ? i_ctl.new_entry : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

endmodule

/* rtl/core/gnms_iou.sv */
// ----------------------------------------------------------------------------
// gnms_iou
// Multi-cycle overlap test of a candidate against one kept box.
// ----------------------------------------------------------------------------
module gnms_iou
    import gnms_pkg::*;
(
    input  logic       i_clk,
    input  t_state     i_state,
    input  t_entry     i_cand,
    input  t_entry     i_kept,
    input  logic [7:0] i_thr,
    output logic       o_supp
);

    logic [16:0] w_ax2, w_ay2, w_bx2, w_by2;
    logic [16:0] w_ix1, w_iy1, w_ix2, w_iy2;
    logic [16:0] w_iw, w_ih;
    logic        r_hit;
    logic [15:0] r_iw, r_ih, r_aw, r_ah, r_bw, r_bh;
    logic [31:0] r_inter, r_area_a, r_area_b;
    logic [32:0] r_union;
    logic [40:0] r_rhs;

    // Corners and intersection extents.
    always_comb begin
        w_ax2 = {1'b0, i_cand.x} + {1'b0, i_cand.w};
        w_ay2 = {1'b0, i_cand.y} + {1'b0, i_cand.h};
        w_bx2 = {1'b0, i_kept.x} + {1'b0, i_kept.w};
        w_by2 = {1'b0, i_kept.y} + {1'b0, i_kept.h};
        w_ix1 = (i_cand.x > i_kept.x) ? {1'b0, i_cand.x} : {1'b0, i_kept.x};
        w_iy1 = (i_cand.y > i_kept.y) ? {1'b0, i_cand.y} : {1'b0, i_kept.y};
        w_ix2 = (w_ax2 < w_bx2) ? w_ax2 : w_bx2;
        w_iy2 = (w_ay2 < w_by2) ? w_ay2 : w_by2;
        w_iw  = w_ix2 - w_ix1;
        w_ih  = w_iy2 - w_iy1;
    end

    // One step per controller state; the last step leaves the decision.
    always_ff @(posedge i_clk) begin
        case (i_state)
            S_C0: begin
                r_hit <= (i_cand.cls == i_kept.cls) && (w_ix2 > w_ix1) && (w_iy2 > w_iy1);
                r_iw  <= w_iw[15:0];
                r_ih  <= w_ih[15:0];
                r_aw  <= i_cand.w;
                r_ah  <= i_cand.h;
                r_bw  <= i_kept.w;
                r_bh  <= i_kept.h;
            end
            S_C1: begin
                r_inter  <= r_iw * r_ih;
                r_area_a <= r_aw * r_ah;
                r_area_b <= r_bw * r_bh;
            end
            S_C2: begin
                r_union <= {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};
            end
            S_C3: begin
                r_rhs <= i_thr * r_union;
            end
            default: begin
            end
        endcase
    end

    assign o_supp = r_hit && ({1'b0, r_inter, 8'd0} > r_rhs);

endmodule

/* dv/tb_greedy_class_nms.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_class_nms
// Self-checking testbench for the per-class suppression block.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, ties, zero-size boxes and an
// empty run. Random groups of clustered boxes are then loaded and run under
// several threshold and keep-limit settings and several idle patterns. A last
// phase overfills the candidate store. Typed rows are checked against their own result,
// all others against a behavioral model of the sorted store and the greedy walk.
// ----------------------------------------------------------------------------
module tb_greedy_class_nms;
    import gnms_pkg::*;

    // The block is built with a shallower store so that overfilling stays short.
    localparam int STORE_DEPTH = 64;
    localparam int KEEP_MAX    = 32;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic   cmd;
        t_entry e;
    } nms_item_t;

    typedef struct packed {
        t_entry e;
        logic   none;
        logic   last;
    } nms_result_t;

    typedef struct {
        nms_item_t   item;
        bit          typed;
        nms_result_t want;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [7:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_command;
    logic [15:0] i_box_x, i_box_y, i_box_w, i_box_h, i_score;
    logic [7:0]  i_class_tag;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_out_x, o_out_y, o_out_w, o_out_h, o_out_score;
    logic [7:0]  o_out_class;
    logic        o_none_kept;
    logic        o_last;

    greedy_class_nms #(
        .TOP_K   (STORE_DEPTH),
        .MAX_KEEP(KEEP_MAX)
    ) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_command(i_command),
        .i_box_x(i_box_x), .i_box_y(i_box_y), .i_box_w(i_box_w), .i_box_h(i_box_h),
        .i_score(i_score), .i_class_tag(i_class_tag),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_w(o_out_w), .o_out_h(o_out_h),
        .o_out_score(o_out_score), .o_out_class(o_out_class),
        .o_none_kept(o_none_kept), .o_last(o_last)
    );

    // Model state: the sorted candidate store and the two registers.
    t_entry      cand_store[STORE_DEPTH];
    int          cand_count;
    int          kept_idx[KEEP_MAX];
    logic [7:0]  thr_reg;
    logic [5:0]  limit_reg;

    nms_result_t expected_boxes[$];
    int          errors;
    int          send_idle_pct, recv_stall_pct;
    int          loads_sent, runs_sent, results_seen, suppressed_total;
    int          cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // True when box b overlaps box a too much under the current threshold.
    function automatic bit too_close(t_entry a, t_entry b);
        longint unsigned ax2, ay2, bx2, by2, ix1, iy1, ix2, iy2;
        longint unsigned inter, area_a, area_b;
        ax2 = a.x + a.w; ay2 = a.y + a.h;
        bx2 = b.x + b.w; by2 = b.y + b.h;
        ix1 = (a.x > b.x) ? a.x : b.x;
        iy1 = (a.y > b.y) ? a.y : b.y;
        ix2 = (ax2 < bx2) ? ax2 : bx2;
        iy2 = (ay2 < by2) ? ay2 : by2;
        if (ix2 <= ix1 || iy2 <= iy1) return 1'b0;
        inter  = (ix2 - ix1) * (iy2 - iy1);
        area_a = longint'(a.w) * longint'(a.h);
        area_b = longint'(b.w) * longint'(b.h);
        return inter * 256 > longint'(thr_reg) * (area_a + area_b - inter);
    endfunction

    // Insert a box into the sorted store; ties keep load order.
    function automatic void store_box(t_entry e);
        int pos;
        pos = 0;
        while (pos < cand_count && cand_store[pos].score >= e.score) pos++;
        if (cand_count >= STORE_DEPTH) begin
            if (pos >= STORE_DEPTH) return;
            cand_count = STORE_DEPTH - 1;
        end
        for (int k = cand_count; k > pos; k--) cand_store[k] = cand_store[k-1];
        cand_store[pos] = e;
        cand_count++;
    endfunction

    // Greedy walk over the store; appends the kept boxes to the given queue.
    function automatic void suppress_run(ref nms_result_t res[$]);
        int lim, nkept;
        bit sup;
        nms_result_t r;
        lim = (limit_reg == 0) ? 1 : ((limit_reg > KEEP_MAX) ? KEEP_MAX : limit_reg);
        nkept = 0;
        for (int i = 0; i < cand_count && nkept < lim; i++) begin
            sup = 1'b0;
            for (int j = 0; j < nkept && !sup; j++)
                if (cand_store[kept_idx[j]].cls == cand_store[i].cls &&
                    too_close(cand_store[i], cand_store[kept_idx[j]]))
                    sup = 1'b1;
            if (sup) suppressed_total++;
            else kept_idx[nkept++] = i;
        end
        if (nkept == 0) begin
            r = '0; r.none = 1'b1; r.last = 1'b1;
            res.push_back(r);
        end
        for (int k = 0; k < nkept; k++) begin
            r.e = cand_store[kept_idx[k]];
            r.none = 1'b0;
            r.last = (k == nkept - 1);
            res.push_back(r);
        end
        cand_count = 0;
    endfunction

    // Update the model for one accepted item; appends what it predicts to the given queue.
    function automatic void predict_item(nms_item_t it, ref nms_result_t res[$]);
        if (it.cmd == CMD_LOAD) begin
            store_box(it.e);
            loads_sent++;
        end else begin
            suppress_run(res);
            runs_sent++;
        end
    endfunction

    // Send one item; the model is updated at the transfer edge.
    task automatic send_item(nms_item_t it, bit typed = 0,
                             nms_result_t want = '0);
        nms_result_t res[$];
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= it.cmd;
        i_box_x     <= it.e.x;
        i_box_y     <= it.e.y;
        i_box_w     <= it.e.w;
        i_box_h     <= it.e.h;
        i_score     <= it.e.score;
        i_class_tag <= it.e.cls;
        do @(posedge i_clk); while (!o_ready);
        predict_item(it, res);
        if (typed) expected_boxes.push_back(want);
        else foreach (res[k]) expected_boxes.push_back(res[k]);
    endtask

    // Wait until the block is idle, then write one register.
    task automatic write_reg(logic idx, logic [7:0] val);
        i_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IOU_THR) thr_reg = val;
        else limit_reg = val[5:0];
    endtask

    function automatic nms_item_t mk_item(logic cmd, logic [15:0] x, logic [15:0] y,
                                          logic [15:0] w, logic [15:0] h,
                                          logic [15:0] s, logic [7:0] c);
        nms_item_t it;
        it.cmd = cmd;
        it.e = '{x: x, y: y, w: w, h: h, score: s, cls: c};
        return it;
    endfunction

    function automatic nms_item_t rand_item();
        return mk_item(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    endfunction

    // One group: clustered boxes over a few classes with random items mixed in, then a run.
    task automatic send_group(int nmax);
        int n, bx, by;
        logic [15:0] s;
        n  = $urandom_range(1, nmax);
        bx = $urandom_range(0, 60000);
        by = $urandom_range(0, 60000);
        for (int k = 0; k < n; k++) begin
            s = ($urandom_range(3) == 0) ? 16'h8000 : 16'($urandom);
            if ($urandom_range(9) == 0)
                send_item(rand_item());
            else
                send_item(mk_item(CMD_LOAD, 16'(bx + $urandom_range(0, 96)),
                                  16'(by + $urandom_range(0, 96)),
                                  16'($urandom_range(8, 300)),
                                  16'($urandom_range(8, 300)), s,
                                  8'($urandom_range(0, 3))));
        end
        send_item(mk_item(CMD_RUN, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 8'($urandom)));
    endtask

    // Receiver: random stalls, and each result transfer is checked in order.
    always @(posedge i_clk) begin
        nms_result_t got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got.e = '{x: o_out_x, y: o_out_y, w: o_out_w, h: o_out_h,
                      score: o_out_score, cls: o_out_class};
            got.none = o_none_kept;
            got.last = o_last;
            results_seen++;
            if (expected_boxes.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result %p", got);
            end else begin
                want = expected_boxes.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                                 want, got);
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    dir_row_t dir_table[$];

    initial begin
        nms_result_t none_res, top_res;
        logic [7:0] thr_set[4];
        logic [7:0] limit_set[4];
        int idle_set[4];
        int stall_set[4];

        thr_set   = '{8'd0, 8'd255, 8'd115, 8'd60};
        limit_set = '{8'd63, 8'd1, 8'd0, 8'd32};
        idle_set  = '{0, 50, 0, 28};
        stall_set = '{0, 0, 50, 28};
        errors = 0; cycles = 0; results_seen = 0; suppressed_total = 0;
        loads_sent = 0; runs_sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        cand_count = 0; thr_reg = 8'd115; limit_reg = 6'd20;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = 1'b0; i_cfg_data = '0;
        i_valid = 1'b0; i_ready = 1'b0; i_command = 1'b0;
        i_box_x = '0; i_box_y = '0; i_box_w = '0; i_box_h = '0;
        i_score = '0; i_class_tag = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; typed rows carry their result, the rest use the model.
        none_res = '0; none_res.none = 1'b1; none_res.last = 1'b1;
        top_res.e = '{x: 16'hFFFF, y: 16'hFFFF, w: 16'hFFFF, h: 16'hFFFF,
                      score: 16'hFFFF, cls: 8'hFF};
        top_res.none = 1'b0; top_res.last = 1'b1;
        dir_table.push_back('{mk_item(CMD_RUN, 0, 0, 0, 0, 0, 0), 1, none_res});
        dir_table.push_back('{mk_item(CMD_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 16'hFFFF, 8'hFF), 0, '0});
        dir_table.push_back('{mk_item(CMD_RUN, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 16'hFFFF, 1), 1, top_res});
        // Identical boxes: ties by load order, same class suppressed, other kept.
        dir_table.push_back('{mk_item(CMD_LOAD, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0), 0, '0});
        dir_table.push_back('{mk_item(CMD_LOAD, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0), 0, '0});
        dir_table.push_back('{mk_item(CMD_LOAD, 0, 0, 16'hFFFF, 16'hFFFF, 0, 1), 0, '0});
        dir_table.push_back('{mk_item(CMD_LOAD, 5, 5, 16'hFFFF, 16'hFFFF, 7, 0), 0, '0});
        dir_table.push_back('{mk_item(CMD_RUN, 0, 0, 0, 0, 0, 0), 0, '0});
        // Zero-size boxes never overlap.
        dir_table.push_back('{mk_item(CMD_LOAD, 100, 100, 0, 50, 300, 2), 0, '0});
        dir_table.push_back('{mk_item(CMD_LOAD, 100, 100, 0, 50, 300, 2), 0, '0});
        dir_table.push_back('{mk_item(CMD_LOAD, 100, 100, 50, 0, 200, 2), 0, '0});
        dir_table.push_back('{mk_item(CMD_LOAD, 100, 100, 50, 0, 200, 2), 0, '0});
        dir_table.push_back('{mk_item(CMD_RUN, 0, 0, 0, 0, 0, 0), 0, '0});
        // Partial overlap near the default threshold.
        dir_table.push_back('{mk_item(CMD_LOAD, 0, 0, 160, 160, 900, 3), 0, '0});
        dir_table.push_back('{mk_item(CMD_LOAD, 40, 0, 160, 160, 800, 3), 0, '0});
        dir_table.push_back('{mk_item(CMD_LOAD, 80, 0, 160, 160, 700, 3), 0, '0});
        dir_table.push_back('{mk_item(CMD_LOAD, 160, 0, 160, 160, 600, 3), 0, '0});
        dir_table.push_back('{mk_item(CMD_RUN, 0, 0, 0, 0, 0, 0), 0, '0});
        dir_table.push_back('{mk_item(CMD_RUN, 0, 0, 0, 0, 0, 0), 1, none_res});
        foreach (dir_table[r])
            send_item(dir_table[r].item, dir_table[r].typed, dir_table[r].want);

        // Random phases, each under its own register setting and idle pattern.
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_IOU_THR, thr_set[p]);
            write_reg(CFG_KEEP_LIMIT, limit_set[p]);
            send_idle_pct  = idle_set[p];
            recv_stall_pct = stall_set[p];
            for (int g = 0; g < 4; g++) send_group((g == 3) ? 20 : 10);
        end

        // Overfill the store so that the lowest entries get replaced or dropped.
        write_reg(CFG_IOU_THR, 8'd200);
        write_reg(CFG_KEEP_LIMIT, 8'd32);
        send_idle_pct = 0; recv_stall_pct = 20;
        for (int k = 0; k < STORE_DEPTH + 6; k++)
            send_item(mk_item(CMD_LOAD, 16'($urandom), 16'($urandom),
                              16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                              16'($urandom_range(0, 4000)), 8'($urandom_range(0, 7))));
        send_item(mk_item(CMD_RUN, 0, 0, 0, 0, 0, 0));

        i_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d loads and %0d runs, %0d results checked, %0d boxes suppressed.",
                 loads_sent, runs_sent, results_seen, suppressed_total);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("Mismatches: %0d", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/gnms_pkg.sv
rtl/core/gnms_cell.sv
rtl/core/gnms_iou.sv
rtl/core/greedy_class_nms.sv
dv/tb_greedy_class_nms.sv
